// File: design/thermo_hygro_segment_lcd_encoder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the thermo-hygro segment LCD encoder
// Shared property forms, clocked on the rising edge and off during reset.
// ----------------------------------------------------------------------------
`ifndef THERMO_HYGRO_SEGMENT_LCD_ENCODER_DEFINES_SVH
`define THERMO_HYGRO_SEGMENT_LCD_ENCODER_DEFINES_SVH

// Same-cycle implication
`define THLCD_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define THLCD_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/thlcd_pkg.sv
// ----------------------------------------------------------------------------
// thlcd_pkg
// Constants, panel font and pixel map for the thermo-hygro LCD encoder.
// ----------------------------------------------------------------------------
package thlcd_pkg;

    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 72;
    localparam int unsigned RAM_BITS   = 72;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DRY_BELOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WET_ABOVE = 1'd1;

    localparam logic [CFG_DATA_W-1:0] DRY_BELOW_RST = 7'd40;
    localparam logic [CFG_DATA_W-1:0] WET_ABOVE_RST = 7'd60;

    localparam logic signed [15:0] TEMP_MAX = 16'sd1999;
    localparam logic signed [15:0] TEMP_MIN = -16'sd1999;
    localparam logic signed [11:0] HUM_MAX  = 12'sd990;

    // digit code that draws nothing
    localparam logic [3:0] DIGIT_BLANK = 4'd15;

    // hardware segment marker for an unwired panel SEG
    localparam logic [4:0] NO_HW = 5'h1F;

    typedef struct packed {
        logic [1:0] com;
        logic [3:0] pseg;
    } pix_t;

    typedef pix_t digit_map_t [7];

    // panel SEG to hardware segment
    localparam logic [4:0] WIRING [14] = '{
        NO_HW, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9,
        5'd16, 5'd17, 5'd14, 5'd15, 5'd0, 5'd1, 5'd2
    };

    // {COM, panel SEG} for segments A..G of each digit
    localparam digit_map_t POS_T_TENS = '{
        '{2'd3, 4'd3}, '{2'd2, 4'd3}, '{2'd1, 4'd3}, '{2'd0, 4'd2},
        '{2'd1, 4'd2}, '{2'd3, 4'd2}, '{2'd2, 4'd2}
    };
    localparam digit_map_t POS_T_UNITS = '{
        '{2'd3, 4'd5}, '{2'd2, 4'd5}, '{2'd1, 4'd5}, '{2'd0, 4'd4},
        '{2'd1, 4'd4}, '{2'd3, 4'd4}, '{2'd2, 4'd4}
    };
    localparam digit_map_t POS_T_TENTH = '{
        '{2'd3, 4'd12}, '{2'd2, 4'd12}, '{2'd1, 4'd12}, '{2'd0, 4'd11},
        '{2'd1, 4'd11}, '{2'd3, 4'd11}, '{2'd2, 4'd11}
    };
    localparam digit_map_t POS_H_TENS = '{
        '{2'd0, 4'd8}, '{2'd1, 4'd8}, '{2'd2, 4'd8}, '{2'd3, 4'd7},
        '{2'd2, 4'd7}, '{2'd0, 4'd7}, '{2'd1, 4'd7}
    };
    localparam digit_map_t POS_H_UNITS = '{
        '{2'd0, 4'd10}, '{2'd1, 4'd10}, '{2'd2, 4'd10}, '{2'd3, 4'd9},
        '{2'd2, 4'd9}, '{2'd0, 4'd9}, '{2'd1, 4'd9}
    };

    // single pixels
    localparam pix_t PIX_MINUS   = '{2'd2, 4'd1};
    localparam pix_t PIX_HUNDRED = '{2'd1, 4'd1};
    localparam pix_t PIX_CELSIUS = '{2'd1, 4'd13};
    localparam pix_t PIX_DP      = '{2'd0, 4'd5};
    localparam pix_t PIX_PERCENT = '{2'd3, 4'd10};
    localparam pix_t PIX_DRY     = '{2'd3, 4'd6};
    localparam pix_t PIX_COMFORT = '{2'd0, 4'd6};
    localparam pix_t PIX_WET     = '{2'd3, 4'd8};

    // bit of the flat RAM image {ram_high, ram_mid, ram_low}
    function automatic logic [6:0] pix_bit(input pix_t p);
        logic [4:0] hw;
        hw = WIRING[p.pseg];
        return {hw, p.com};
    endfunction

    function automatic logic pix_wired(input pix_t p);
        return WIRING[p.pseg] != NO_HW;
    endfunction

    // seven-segment font, bit0 = A .. bit6 = G
    function automatic logic [6:0] glyph(input logic [3:0] d);
        logic [6:0] g;
        unique case (d)
            4'd0:    g = 7'h3F;
            4'd1:    g = 7'h06;
            4'd2:    g = 7'h5B;
            4'd3:    g = 7'h4F;
            4'd4:    g = 7'h66;
            4'd5:    g = 7'h6D;
            4'd6:    g = 7'h7D;
            4'd7:    g = 7'h07;
            4'd8:    g = 7'h7F;
            4'd9:    g = 7'h6F;
            default: g = 7'h00;
        endcase
        return g;
    endfunction

    // x / 10 by reciprocal, exact for x below 16384
    function automatic logic [10:0] div10(input logic [13:0] x);
        logic [27:0] p;
        p = {14'd0, x} * 28'd6554;
        return p[26:16];
    endfunction

endpackage

// File: design/thermo_hygro_segment_lcd_encoder.sv
// ----------------------------------------------------------------------------
// thermo_hygro_segment_lcd_encoder
// Turns one temperature/humidity reading into the three LCD RAM words.
// ----------------------------------------------------------------------------
//  channel  | ports                          | contents
//  ---------+--------------------------------+------------------------------------
//  input    | s_tvalid s_tready s_tdata[31:0]| temp_tenths, force_minus,
//           |                                | celsius_mark, hum_tenths
//  result   | m_tvalid m_tready m_tdata[71:0]| ram_low, ram_mid, ram_high
//  config   | cfg_we cfg_index cfg_wdata[6:0]| 0: dry_below, 1: wet_above
//
//  One transaction per cycle sustained while m_tready is high; an accepted item reaches
//  m_tvalid through four register stages (clamp, two divide-by-ten stages, digit
//  encode/output register).
//  Each stage holds its item while the one downstream is full and stalled, so
//  s_tready can stay high while a result waits, until the pipe fills.
//  aresetn (synchronous) empties the pipe and loads the threshold defaults.
// ----------------------------------------------------------------------------
`include "thermo_hygro_segment_lcd_encoder_defines.svh"

module thermo_hygro_segment_lcd_encoder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [15:0] temp_tenths, [16] force_minus, [17] celsius_mark,
    // [29:18] hum_tenths, [31:30] zero
    input  logic [thlcd_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [31:0] ram_low, [63:32] ram_mid, [71:64] ram_high
    output logic [thlcd_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                 cfg_we,
    input  logic [thlcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [thlcd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // configuration
    logic [6:0] dry_below_reg;
    logic [6:0] wet_above_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dry_below_reg <= thlcd_pkg::DRY_BELOW_RST;
            wet_above_reg <= thlcd_pkg::WET_ABOVE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                thlcd_pkg::REG_DRY_BELOW: dry_below_reg <= cfg_wdata;
                thlcd_pkg::REG_WET_ABOVE: wet_above_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage valids and flow control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4     = !v4_reg || m_tready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: clamp, magnitude, rounding offset ----------------
    logic signed [15:0] temp_in;
    logic signed [11:0] hum_in;
    logic signed [15:0] temp_c;
    logic signed [11:0] hum_c;
    logic [10:0] t1_next, t1_reg;
    logic [9:0]  hx1_next, hx1_reg;
    logic        minus1_next, minus1_reg;
    logic        cel1_reg, cel2_reg, cel3_reg;
    logic        minus2_reg, minus3_reg;

    assign temp_in = s_tdata[15:0];
    assign hum_in  = s_tdata[29:18];

    always_comb begin
        priority if (temp_in > thlcd_pkg::TEMP_MAX) temp_c = thlcd_pkg::TEMP_MAX;
        else if (temp_in < thlcd_pkg::TEMP_MIN)      temp_c = thlcd_pkg::TEMP_MIN;
        else                                         temp_c = temp_in;

        priority if (hum_in > thlcd_pkg::HUM_MAX) hum_c = thlcd_pkg::HUM_MAX;
        else if (hum_in < 12'sd0)                 hum_c = 12'sd0;
        else                                      hum_c = hum_in;

        minus1_next = temp_c[15] || s_tdata[16];
        t1_next     = temp_c[15] ? 11'(-temp_c) : temp_c[10:0];
        // round half up: add five tenths before the divide
        hx1_next    = hum_c[9:0] + 10'd5;
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            t1_reg     <= t1_next;
            hx1_reg    <= hx1_next;
            minus1_reg <= minus1_next;
            cel1_reg   <= s_tdata[17];
        end
    end

    // ---------------- stage 2: first divide by ten ----------------
    logic [7:0]  q1_next, q1_reg;
    logic [3:0]  tenth2_next, tenth2_reg, tenth3_reg;
    logic [6:0]  h2_next, h2_reg;
    logic [10:0] q1_x10;

    always_comb begin
        q1_next     = 8'(thlcd_pkg::div10({3'd0, t1_reg}));
        q1_x10      = {3'd0, q1_next} * 11'd10;
        tenth2_next = 4'(t1_reg - q1_x10);
        h2_next     = 7'(thlcd_pkg::div10({4'd0, hx1_reg}));
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            q1_reg     <= q1_next;
            tenth2_reg <= tenth2_next;
            h2_reg     <= h2_next;
            minus2_reg <= minus1_reg;
            cel2_reg   <= cel1_reg;
        end
    end

    // ---------------- stage 3: second divide by ten, icons ----------------
    logic [4:0] q2_next, q2_reg;
    logic [3:0] units3_next, units3_reg;
    logic [3:0] htens3_next, htens3_reg;
    logic [3:0] hunits3_next, hunits3_reg;
    logic       dry3_next, dry3_reg;
    logic       wet3_next, wet3_reg;
    logic [7:0] q2_x10;
    logic [6:0] ht_x10;

    always_comb begin
        q2_next      = 5'(thlcd_pkg::div10({6'd0, q1_reg}));
        q2_x10       = {3'd0, q2_next} * 8'd10;
        units3_next  = 4'(q1_reg - q2_x10);
        htens3_next  = 4'(thlcd_pkg::div10({7'd0, h2_reg}));
        ht_x10       = {3'd0, htens3_next} * 7'd10;
        hunits3_next = 4'(h2_reg - ht_x10);
        dry3_next    = h2_reg < dry_below_reg;
        wet3_next    = h2_reg > wet_above_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            q2_reg      <= q2_next;
            units3_reg  <= units3_next;
            tenth3_reg  <= tenth2_reg;
            htens3_reg  <= htens3_next;
            hunits3_reg <= hunits3_next;
            dry3_reg    <= dry3_next;
            wet3_reg    <= wet3_next;
            minus3_reg  <= minus2_reg;
            cel3_reg    <= cel2_reg;
        end
    end

    // ---------------- stage 4: digits to pixels, output register ----------------
    logic                               hund;
    logic [4:0]                         tens_raw;
    logic [3:0]                         t_tens_d;
    logic [3:0]                         h_tens_d;
    logic [6:0]                         g_tt, g_tu, g_tf, g_ht, g_hu;
    logic [thlcd_pkg::RAM_BITS-1:0]     ram_next, ram_reg;

    always_comb begin
        hund     = q2_reg >= 5'd10;
        tens_raw = hund ? (q2_reg - 5'd10) : q2_reg;
        // blank the tens digit when hundreds and tens are both zero
        t_tens_d = (!hund && tens_raw == 5'd0) ? thlcd_pkg::DIGIT_BLANK : tens_raw[3:0];
        h_tens_d = (htens3_reg == 4'd0) ? thlcd_pkg::DIGIT_BLANK : htens3_reg;

        g_tt = thlcd_pkg::glyph(t_tens_d);
        g_tu = thlcd_pkg::glyph(units3_reg);
        g_tf = thlcd_pkg::glyph(tenth3_reg);
        g_ht = thlcd_pkg::glyph(h_tens_d);
        g_hu = thlcd_pkg::glyph(hunits3_reg);

        ram_next = '0;
        for (int i = 0; i < 7; i++) begin
            if (g_tt[i]) ram_next[thlcd_pkg::pix_bit(thlcd_pkg::POS_T_TENS[i])]  = 1'b1;
            if (g_tu[i]) ram_next[thlcd_pkg::pix_bit(thlcd_pkg::POS_T_UNITS[i])] = 1'b1;
            if (g_tf[i]) ram_next[thlcd_pkg::pix_bit(thlcd_pkg::POS_T_TENTH[i])] = 1'b1;
            if (g_ht[i]) ram_next[thlcd_pkg::pix_bit(thlcd_pkg::POS_H_TENS[i])]  = 1'b1;
            if (g_hu[i]) ram_next[thlcd_pkg::pix_bit(thlcd_pkg::POS_H_UNITS[i])] = 1'b1;
        end

        ram_next[thlcd_pkg::pix_bit(thlcd_pkg::PIX_MINUS)]   = minus3_reg;
        ram_next[thlcd_pkg::pix_bit(thlcd_pkg::PIX_HUNDRED)] = hund;
        ram_next[thlcd_pkg::pix_bit(thlcd_pkg::PIX_CELSIUS)] = cel3_reg;
        ram_next[thlcd_pkg::pix_bit(thlcd_pkg::PIX_DP)]      = 1'b1;
        ram_next[thlcd_pkg::pix_bit(thlcd_pkg::PIX_PERCENT)] = 1'b1;
        ram_next[thlcd_pkg::pix_bit(thlcd_pkg::PIX_DRY)]     = dry3_reg;
        ram_next[thlcd_pkg::pix_bit(thlcd_pkg::PIX_COMFORT)] = !dry3_reg && !wet3_reg;
        ram_next[thlcd_pkg::pix_bit(thlcd_pkg::PIX_WET)]     = wet3_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            ram_reg <= ram_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = ram_reg;

    // ---------------- assertions ----------------
    `THLCD_ASSERT_NXT(a_accept_fills_stage1, aclk, aresetn,
        s_tvalid && s_tready, v1_reg,
        "accepted transaction did not reach stage 1")

    `THLCD_ASSERT_IMP(a_fixed_marks_lit, aclk, aresetn,
        m_tvalid,
        m_tdata[thlcd_pkg::pix_bit(thlcd_pkg::PIX_DP)] &&
        m_tdata[thlcd_pkg::pix_bit(thlcd_pkg::PIX_PERCENT)],
        "decimal point or percent mark missing")

    `THLCD_ASSERT_IMP(a_comfort_exclusive, aclk, aresetn,
        m_tvalid && m_tdata[thlcd_pkg::pix_bit(thlcd_pkg::PIX_COMFORT)],
        !m_tdata[thlcd_pkg::pix_bit(thlcd_pkg::PIX_DRY)] &&
        !m_tdata[thlcd_pkg::pix_bit(thlcd_pkg::PIX_WET)],
        "comfort icon lit together with dry or wet")

    `THLCD_ASSERT_NXT(a_stage3_holds, aclk, aresetn,
        v3_reg && !adv3, v3_reg && $stable(q2_reg) && $stable(hunits3_reg),
        "stage 3 lost or changed its item while stalled")

endmodule

// File: test/thermo_hygro_segment_lcd_encoder_tb.sv
// ----------------------------------------------------------------------------
// thermo_hygro_segment_lcd_encoder_tb
// Drives temperature/humidity readings into the LCD encoder with random gaps
// and back-pressure. Each accepted reading is turned into the expected three
// LCD RAM words by an independent model of the panel font and pixel map, and
// every result transaction is checked against the oldest pending prediction.
// ----------------------------------------------------------------------------
module thermo_hygro_segment_lcd_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY   = 4;
    localparam int TAIL_CYCLES    = PIPE_LATENCY + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 260;

    typedef enum int {
        DIG_T_TENS, DIG_T_UNITS, DIG_T_TENTH, DIG_H_TENS, DIG_H_UNITS
    } digit_pos_t;

    // laid out like m_tdata: ram_low in the lowest bits
    typedef struct packed {
        logic [7:0]  ram_high;
        logic [31:0] ram_mid;
        logic [31:0] ram_low;
    } ram_words_t;

    // segments A..G in bits 0..6
    localparam logic [6:0] SEG_FONT [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // panel SEG to hardware segment, -1 where not wired
    localparam int HW_OF_PSEG [14] = '{-1, 4, 5, 6, 7, 8, 9, 16, 17, 14, 15, 0, 1, 2};

    // {COM, panel SEG} of segments A..G, indexed by digit_pos_t
    localparam int DIGIT_COM [5][7] = '{
        '{3, 2, 1, 0, 1, 3, 2}, '{3, 2, 1, 0, 1, 3, 2}, '{3, 2, 1, 0, 1, 3, 2},
        '{0, 1, 2, 3, 2, 0, 1}, '{0, 1, 2, 3, 2, 0, 1}
    };
    localparam int DIGIT_PSEG [5][7] = '{
        '{3, 3, 3, 2, 2, 2, 2}, '{5, 5, 5, 4, 4, 4, 4}, '{12, 12, 12, 11, 11, 11, 11},
        '{8, 8, 8, 7, 7, 7, 7}, '{10, 10, 10, 9, 9, 9, 9}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // [15:0] temp_tenths, [16] force_minus, [17] celsius_mark,
    // [29:18] hum_tenths, [31:30] zero
    logic [thlcd_pkg::IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [31:0] ram_low, [63:32] ram_mid, [71:64] ram_high
    logic [thlcd_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [thlcd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [thlcd_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    logic [thlcd_pkg::CFG_DATA_W-1:0]  dry_mirror = thlcd_pkg::DRY_BELOW_RST;
    logic [thlcd_pkg::CFG_DATA_W-1:0]  wet_mirror = thlcd_pkg::WET_ABOVE_RST;

    ram_words_t pending_words [$];
    bit         no_idle        = 1'b0;
    int         fail_count     = 0;
    int         readings_sent  = 0;
    int         words_checked  = 0;
    int         settings_count = 0;
    int         quiet_cycles   = 0;
    int         ready_hold     = 0;
    logic       ready_next     = 1'b0;

    thermo_hygro_segment_lcd_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // panel model
    // ------------------------------------------------------------------
    function automatic logic [71:0] light_pixel(input logic [71:0] img, input int com,
                                                input int pseg, input logic on);
        int hw;
        hw = HW_OF_PSEG[pseg];
        if (on && hw >= 0)
            img[hw * 4 + com] = 1'b1;
        return img;
    endfunction

    // digit above 9 draws nothing
    function automatic logic [71:0] draw_digit(input logic [71:0] img, input digit_pos_t pos,
                                               input int digit);
        logic [6:0] segs;
        segs = (digit <= 9) ? SEG_FONT[digit] : 7'h00;
        for (int i = 0; i < 7; i++)
            img = light_pixel(img, DIGIT_COM[pos][i], DIGIT_PSEG[pos][i], segs[i]);
        return img;
    endfunction

    function automatic ram_words_t predict_ram(input logic signed [15:0] temp,
                                               input logic fm, input logic cm,
                                               input logic signed [11:0] hum,
                                               input logic [6:0] dry, input logic [6:0] wet);
        logic [71:0] img;
        int t, mag, h, pct, tens;
        logic neg;
        t = int'(temp);
        if (t > 1999)
            t = 1999;
        if (t < -1999)
            t = -1999;
        neg = t < 0;
        mag = neg ? -t : t;
        tens = (mag / 100) % 10;
        img = '0;
        img = light_pixel(img, 2, 1, neg | fm);                 // minus
        img = light_pixel(img, 1, 1, mag >= 1000);              // leading one
        img = draw_digit(img, DIG_T_TENS, (mag < 100) ? 10 : tens);
        img = draw_digit(img, DIG_T_UNITS, (mag / 10) % 10);
        img = draw_digit(img, DIG_T_TENTH, mag % 10);
        img = light_pixel(img, 1, 13, cm);                      // Celsius
        img = light_pixel(img, 0, 5, 1'b1);                     // decimal point

        h = int'(hum);
        if (h > 990)
            h = 990;
        if (h < 0)
            h = 0;
        pct = (h + 5) / 10;
        img = draw_digit(img, DIG_H_TENS, (pct < 10) ? 10 : pct / 10);
        img = draw_digit(img, DIG_H_UNITS, pct % 10);
        img = light_pixel(img, 3, 10, 1'b1);                    // percent
        img = light_pixel(img, 3, 6, pct < int'(dry));
        img = light_pixel(img, 0, 6, pct >= int'(dry) && pct <= int'(wet));
        img = light_pixel(img, 3, 8, pct > int'(wet));
        return ram_words_t'(img);
    endfunction

    // ------------------------------------------------------------------
    // idling
    // ------------------------------------------------------------------
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    always @(posedge aclk) begin
        if (ready_hold == 0) begin
            if (no_idle || $urandom_range(0, 99) < 65) begin
                ready_next = 1'b1;
                ready_hold = $urandom_range(1, 8);
            end else begin
                ready_next = 1'b0;
                ready_hold = idle_length();
            end
        end
        ready_hold--;
        m_tready <= ready_next;
    end

    // ------------------------------------------------------------------
    // result check and watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        ram_words_t want;
        ram_words_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = ram_words_t'(m_tdata);
            if (pending_words.size() == 0) begin
                $error("result transaction with no reading pending: %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_words.pop_front();
                words_checked++;
                if (got.ram_low !== want.ram_low) begin
                    $error("ram_low: expected %h, actual %h", want.ram_low, got.ram_low);
                    fail_count++;
                end
                if (got.ram_mid !== want.ram_mid) begin
                    $error("ram_mid: expected %h, actual %h", want.ram_mid, got.ram_mid);
                    fail_count++;
                end
                if (got.ram_high !== want.ram_high) begin
                    $error("ram_high: expected %h, actual %h", want.ram_high, got.ram_high);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_reading(input int temp, input bit fm, input bit cm, input int hum);
        int gap;
        gap = (no_idle || $urandom_range(0, 99) < 55) ? 0 : idle_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {2'b00, hum[11:0], cm, fm, temp[15:0]};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_words.push_back(predict_ram(temp[15:0], fm, cm, hum[11:0],
                                            dry_mirror, wet_mirror));
        readings_sent++;
    endtask

    // drop valid and hold until every predicted result has been checked
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic set_thresholds(input logic [6:0] dry, input logic [6:0] wet);
        cfg_we    <= 1'b1;
        cfg_index <= thlcd_pkg::REG_DRY_BELOW;
        cfg_wdata <= dry;
        @(posedge aclk);
        cfg_index <= thlcd_pkg::REG_WET_ABOVE;
        cfg_wdata <= wet;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        dry_mirror = dry;
        wet_mirror = wet;
        settings_count++;
    endtask

    function automatic int random_temp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return int'($urandom_range(0, 65535));
        if (r < 85)
            return int'($urandom_range(0, 4200)) - 2100;
        return int'($urandom_range(0, 40)) - 20;
    endfunction

    // mostly in range, some aimed at the icon thresholds, some raw
    function automatic int random_hum();
        int r, base;
        r = $urandom_range(0, 99);
        if (r < 30)
            return int'($urandom_range(0, 4095));
        if (r < 50) begin
            base = $urandom_range(0, 1) ? int'(dry_mirror) : int'(wet_mirror);
            base = base + int'($urandom_range(0, 4)) - 2;
            return base * 10 + int'($urandom_range(0, 9)) - 5;
        end
        return int'($urandom_range(0, 1010)) - 20;
    endfunction

    task automatic send_random_reading();
        send_reading(random_temp(), $urandom_range(0, 1), $urandom_range(0, 1), random_hum());
    endtask

    function automatic logic [6:0] random_threshold();
        if ($urandom_range(0, 99) < 70)
            return 7'($urandom_range(0, 99));
        return 7'($urandom_range(0, 127));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // icon edges at the reset thresholds, including rounding half up
    task automatic test_reset_thresholds();
        send_reading(250, 1'b0, 1'b1, 394);
        send_reading(250, 1'b0, 1'b1, 395);
        send_reading(250, 1'b0, 1'b0, 600);
        send_reading(250, 1'b0, 1'b0, 604);
        send_reading(250, 1'b0, 1'b1, 605);
    endtask

    // blanking, leading one, minus sign and saturation
    task automatic test_temperature_extremes();
        send_reading(0,      1'b0, 1'b0, 500);
        send_reading(0,      1'b1, 1'b1, 500);
        send_reading(-1,     1'b0, 1'b1, 500);
        send_reading(9,      1'b0, 1'b0, 500);
        send_reading(99,     1'b0, 1'b1, 500);
        send_reading(100,    1'b0, 1'b0, 500);
        send_reading(999,    1'b0, 1'b1, 500);
        send_reading(1000,   1'b0, 1'b0, 500);
        send_reading(1999,   1'b0, 1'b1, 500);
        send_reading(2000,   1'b1, 1'b0, 500);
        send_reading(-2000,  1'b0, 1'b1, 500);
        send_reading(32767,  1'b0, 1'b0, 500);
        send_reading(-32768, 1'b1, 1'b1, 500);
    endtask

    // clamping at both ends and tens blanking
    task automatic test_humidity_extremes();
        send_reading(123, 1'b0, 1'b1, -2048);
        send_reading(123, 1'b0, 1'b1, -1);
        send_reading(123, 1'b0, 1'b0, 4);
        send_reading(123, 1'b0, 1'b1, 985);
        send_reading(123, 1'b0, 1'b0, 991);
        send_reading(123, 1'b0, 1'b1, 2047);
    endtask

    // all-zero, all-ones, above 99 and crossed thresholds
    task automatic test_threshold_settings();
        logic [6:0] dry_set [6] = '{7'd0, 7'd127, 7'd99, 7'd0, 7'd127, 7'd50};
        logic [6:0] wet_set [6] = '{7'd0, 7'd127, 7'd0, 7'd99, 7'd0, 7'd50};
        for (int s = 0; s < 6; s++) begin
            wait_results_drained();
            set_thresholds(dry_set[s], wet_set[s]);
            for (int i = 0; i < 30; i++)
                send_random_reading();
        end
    endtask

    task automatic test_random_readings();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_results_drained();
            if (p == 0)
                set_thresholds(thlcd_pkg::DRY_BELOW_RST, thlcd_pkg::WET_ABOVE_RST);
            else
                set_thresholds(random_threshold(), random_threshold());
            no_idle = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2)
                    wait_results_drained();
                send_random_reading();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_thresholds();
        test_temperature_extremes();
        test_humidity_extremes();
        test_threshold_settings();
        test_random_readings();
        wait_results_drained();

        $display("covered %0d readings, %0d result transactions checked",
                 readings_sent, words_checked);
        $display("across %0d threshold settings, with and without idling", settings_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/thlcd_pkg.sv
design/thermo_hygro_segment_lcd_encoder.sv
test/thermo_hygro_segment_lcd_encoder_tb.sv
